@@ rtl/wrs_pkg.sv @@
package wrs_pkg;

   localparam int MAX_POINTS_DEFAULT = 256;

   localparam int SAMPLE_W   = 16;
   localparam int FRAC_BITS  = 16;
   localparam int SLOPE_W    = 33;
   localparam int MEAN_W     = 32;
   localparam int SPREAD_W   = 16;
   localparam int NPTS_W     = 9;
   localparam int QUO_W      = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 9;

   localparam logic [NPTS_W-1:0] NPTS_RESET = NPTS_W'(16);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_N_POINTS = 4'd0,
      CSR_BACKWARD = 4'd1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_ACC,
      ST_PROD,
      ST_NUM,
      ST_MAG,
      ST_SSTART,
      ST_SWAIT,
      ST_MSTART,
      ST_MWAIT,
      ST_OUT
   } st_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_stat_type;

endpackage

@@ rtl/wrs_divider.sv @@
module wrs_divider
   import wrs_pkg::*;
#(
   parameter int DVW = 65,
   parameter int DSW = 36
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   input  logic [DVW-1:0] dividend,
   input  logic [DSW-1:0] divisor,
   output logic [DVW-1:0] quotient,
   output div_stat_type   stat
);

   localparam int CTW = $clog2(DVW + 1);

   logic           busy_ff, busy_in;
   logic           done_ff, done_in;
   logic [CTW-1:0] cnt_ff, cnt_in;
   logic [DSW-1:0] rem_ff, rem_in;
   logic [DVW-1:0] dq_ff, dq_in;
   logic [DSW-1:0] div_ff, div_in;

   logic [DSW:0]   trial;
   logic [DSW+1:0] diff;
   logic           fits;

   // restoring division, one quotient bit per cycle, quotient shifts into dq
   always_comb begin
      trial = {rem_ff, dq_ff[DVW-1]};
      diff  = {1'b0, trial} - {2'b00, div_ff};
      fits  = !diff[DSW+1];

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dq_in   = dq_ff;
      div_in  = div_ff;

      if (start && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = CTW'(DVW);
         rem_in  = '0;
         dq_in   = dividend;
         div_in  = divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DSW-1:0] : trial[DSW-1:0];
         dq_in  = {dq_ff[DVW-2:0], fits};
         cnt_in = cnt_ff - CTW'(1);
         if (cnt_ff == CTW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dq_ff  <= dq_in;
      div_ff <= div_in;
   end

   assign quotient  = dq_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

   a_rem_below_div: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> rem_ff < div_ff)
      else $error("partial remainder not below divisor");

   a_start_loads: assert property (@(posedge clock) disable iff (reset)
      start && !busy_ff |=> busy_ff && cnt_ff == CTW'(DVW))
      else $error("start did not begin a full division");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("done without a finished division");

endmodule

@@ rtl/window_regression_slope.sv @@
// channel   | dir | handshake                 | payload
// req       | in  | req_valid / req_stall     | req_sample
// rsp       | out | rsp_valid / rsp_stall     | rsp_slope, rsp_mean, rsp_spread
// csr       | in  | csr_valid / csr_ready     | csr_index, csr_data
//
// a sample inside a window is taken whenever no csr write is offered; the last sample of a
// window holds req off while the products, numerator and magnitude are registered and the
// bit-serial divider forms first the slope and then the mean, and after that until rsp is free.
// the divider's dividend is DVW = 3*clog2(MAX_POINTS+1) + 38 bits wide.
// synchronous reset sets n_points to 16, backward to 0 and empties the window.
// a result waits in the output register under rsp_stall while samples of the
// next window keep coming in; only a finished window waits for it to drain.
module window_regression_slope
   import wrs_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,

   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic signed [SAMPLE_W-1:0]   req_sample,

   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic signed [SLOPE_W-1:0]    rsp_slope,
   output logic signed [MEAN_W-1:0]     rsp_mean,
   output logic        [SPREAD_W-1:0]   rsp_spread,

   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic        [CSR_IDX_W-1:0]  csr_index,
   input  logic        [CSR_DATA_W-1:0] csr_data
);

   localparam int NW   = $clog2(MAX_POINTS + 1);
   localparam int PW   = (NW > NPTS_W) ? NW : NPTS_W;
   localparam int YW   = SAMPLE_W + NW;
   localparam int XYW  = 2 * NW + SAMPLE_W;
   localparam int SXW  = 2 * NW;
   localparam int PRW  = 3 * NW + SAMPLE_W + 1;
   localparam int NUMW = PRW + 1;
   localparam int DVW  = NUMW + 4 + FRAC_BITS;
   localparam int DSW  = 4 * NW;

   st_type state_ff, state_in;

   logic [NPTS_W-1:0]          n_points_ff, n_points_in;
   logic                       backward_ff, backward_in;
   logic [NW-1:0]              count_ff, count_in;
   logic signed [YW-1:0]       sum_y_ff, sum_y_in;
   logic signed [XYW-1:0]      sum_xy_ff, sum_xy_in;
   logic signed [SAMPLE_W-1:0] min_ff, min_in;
   logic signed [SAMPLE_W-1:0] max_ff, max_in;

   logic [2*NW-1:0]            nsq_ff, nsq_in;
   logic [DSW-1:0]             d12_ff, d12_in;
   logic [SXW-1:0]             sx_ff, sx_in;
   logic signed [PRW-1:0]      p1_ff, p1_in;
   logic signed [PRW-1:0]      p2_ff, p2_in;
   logic signed [NUMW-1:0]     num_ff, num_in;
   logic                       num_neg_ff, num_neg_in;
   logic [DVW-1:0]             dvd_ff, dvd_in;
   logic [QUO_W-1:0]           slope_q_ff, slope_q_in;
   logic [QUO_W-1:0]           mean_q_ff, mean_q_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [SLOPE_W-1:0]  rsp_slope_ff, rsp_slope_in;
   logic signed [MEAN_W-1:0]   rsp_mean_ff, rsp_mean_in;
   logic [SPREAD_W-1:0]        rsp_spread_ff, rsp_spread_in;

   logic [PW-1:0]              npts_wide;
   logic [NW-1:0]              n_eff;
   logic [SXW:0]               sx_prod;
   logic [NW-1:0]              x_val;
   logic signed [NW+SAMPLE_W:0] xy;
   logic                       accept_req;
   logic                       csr_write;
   logic                       csr_hit;
   logic                       last;
   logic                       out_free;
   logic                       win_done;
   logic [NUMW-1:0]            num_mag;
   logic [NUMW+3:0]            num_mag12;
   logic                       sy_neg;
   logic [YW-1:0]              sy_mag;
   logic [SLOPE_W-1:0]         slope_mag;
   logic [SLOPE_W-1:0]         slope_val;
   logic [MEAN_W-1:0]          mean_val;

   logic                       div_start;
   logic [DVW-1:0]             div_dvd;
   logic [DSW-1:0]             div_dsr;
   logic [DVW-1:0]             div_quo;
   div_stat_type               div_stat;

   // handshake and window control
   always_comb begin
      npts_wide = PW'(n_points_ff);
      if (npts_wide < PW'(2)) begin
         n_eff = NW'(2);
      end else if (npts_wide > PW'(MAX_POINTS)) begin
         n_eff = NW'(MAX_POINTS);
      end else begin
         n_eff = npts_wide[NW-1:0];
      end

      accept_req = req_valid && !req_stall;
      csr_write  = csr_valid && csr_ready;
      csr_hit    = csr_write &&
                   (csr_index == CSR_N_POINTS || csr_index == CSR_BACKWARD);
      last       = (count_ff + NW'(1)) == n_eff;
      out_free   = !rsp_valid_ff || !rsp_stall;
      win_done   = (state_ff == ST_OUT) && out_free;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_ACC:    if (accept_req && last) state_in = ST_PROD;
         ST_PROD:   state_in = ST_NUM;
         ST_NUM:    state_in = ST_MAG;
         ST_MAG:    state_in = ST_SSTART;
         ST_SSTART: state_in = ST_SWAIT;
         ST_SWAIT:  if (div_stat.done) state_in = ST_MSTART;
         ST_MSTART: state_in = ST_MWAIT;
         ST_MWAIT:  if (div_stat.done) state_in = ST_OUT;
         ST_OUT:    if (out_free) state_in = ST_ACC;
         default:   state_in = ST_ACC;
      endcase
   end

   // state outputs
   always_comb begin
      // a config write goes ahead of a sample offered in the same cycle
      req_stall = (state_ff != ST_ACC) || csr_valid;
      csr_ready = (state_ff == ST_ACC);
      div_start = (state_ff == ST_SSTART) || (state_ff == ST_MSTART);
      if (state_ff == ST_SSTART) begin
         div_dvd = dvd_ff;
         div_dsr = d12_ff;
      end else begin
         div_dvd = DVW'({sy_mag, {FRAC_BITS{1'b0}}});
         div_dsr = DSW'(n_eff);
      end
   end

   // datapath
   always_comb begin
      // window constants follow n_points through registers: nsq then d12, and sx
      nsq_in  = (2*NW)'(n_eff) * (2*NW)'(n_eff);
      d12_in  = DSW'(nsq_ff) * DSW'(nsq_ff - (2*NW)'(1));
      sx_prod = (SXW+1)'(n_eff) * ((SXW+1)'(n_eff) + (SXW+1)'(1));
      sx_in   = sx_prod[SXW:1];

      x_val = backward_ff ? (n_eff - count_ff) : (count_ff + NW'(1));
      xy    = $signed({1'b0, x_val}) * req_sample;

      p1_in  = $signed({1'b0, n_eff}) * sum_xy_ff;
      p2_in  = $signed({1'b0, sx_ff}) * sum_y_ff;
      num_in = NUMW'(p1_ff) - NUMW'(p2_ff);

      num_neg_in = num_ff[NUMW-1];
      num_mag    = num_ff[NUMW-1] ? NUMW'(-num_ff) : NUMW'(num_ff);
      // slope = 12*num / (N^2 (N^2-1)), same floor as num / Del
      num_mag12  = (NUMW+4)'({num_mag, 3'b000}) + (NUMW+4)'({num_mag, 2'b00});
      dvd_in     = {num_mag12, {FRAC_BITS{1'b0}}};

      sy_neg = sum_y_ff[YW-1];
      sy_mag = sy_neg ? YW'(-sum_y_ff) : YW'(sum_y_ff);

      slope_q_in = ((state_ff == ST_SWAIT) && div_stat.done) ? div_quo[QUO_W-1:0]
                                                             : slope_q_ff;
      mean_q_in  = ((state_ff == ST_MWAIT) && div_stat.done) ? div_quo[QUO_W-1:0]
                                                             : mean_q_ff;

      slope_mag = {1'b0, slope_q_ff};
      slope_val = num_neg_ff ? -slope_mag : slope_mag;
      mean_val  = sy_neg ? -mean_q_ff : mean_q_ff;

      n_points_in = n_points_ff;
      backward_in = backward_ff;
      count_in    = count_ff;
      sum_y_in    = sum_y_ff;
      sum_xy_in   = sum_xy_ff;
      min_in      = min_ff;
      max_in      = max_ff;

      if (csr_write) begin
         case (csr_index)
            CSR_N_POINTS: n_points_in = csr_data[NPTS_W-1:0];
            CSR_BACKWARD: backward_in = csr_data[0];
            default: ;
         endcase
      end

      if (csr_hit || win_done) begin
         count_in  = '0;
         sum_y_in  = '0;
         sum_xy_in = '0;
      end else if (accept_req) begin
         count_in  = last ? '0 : count_ff + NW'(1);
         sum_y_in  = sum_y_ff + YW'(req_sample);
         sum_xy_in = sum_xy_ff + XYW'(xy);
         if (count_ff == '0) begin
            min_in = req_sample;
            max_in = req_sample;
         end else begin
            if (req_sample < min_ff) min_in = req_sample;
            if (req_sample > max_ff) max_in = req_sample;
         end
      end

      rsp_valid_in  = win_done || (rsp_valid_ff && rsp_stall);
      rsp_slope_in  = win_done ? $signed(slope_val) : rsp_slope_ff;
      rsp_mean_in   = win_done ? $signed(mean_val) : rsp_mean_ff;
      rsp_spread_in = win_done ? SPREAD_W'(max_ff - min_ff) : rsp_spread_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ACC;
         n_points_ff  <= NPTS_RESET;
         backward_ff  <= 1'b0;
         count_ff     <= '0;
         sum_y_ff     <= '0;
         sum_xy_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_points_ff  <= n_points_in;
         backward_ff  <= backward_in;
         count_ff     <= count_in;
         sum_y_ff     <= sum_y_in;
         sum_xy_ff    <= sum_xy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      min_ff        <= min_in;
      max_ff        <= max_in;
      nsq_ff        <= nsq_in;
      d12_ff        <= d12_in;
      sx_ff         <= sx_in;
      p1_ff         <= p1_in;
      p2_ff         <= p2_in;
      num_ff        <= num_in;
      num_neg_ff    <= num_neg_in;
      dvd_ff        <= dvd_in;
      slope_q_ff    <= slope_q_in;
      mean_q_ff     <= mean_q_in;
      rsp_slope_ff  <= rsp_slope_in;
      rsp_mean_ff   <= rsp_mean_in;
      rsp_spread_ff <= rsp_spread_in;
   end

   wrs_divider #(
      .DVW (DVW),
      .DSW (DSW)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_dsr),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_slope  = rsp_slope_ff;
   assign rsp_mean   = rsp_mean_ff;
   assign rsp_spread = rsp_spread_ff;

   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_ACC |-> count_ff < n_eff)
      else $error("sample count reached the window length");

   a_div_done_waited: assert property (@(posedge clock) disable iff (reset)
      div_stat.done |-> (state_ff == ST_SWAIT || state_ff == ST_MWAIT))
      else $error("divider finished outside a wait state");

   a_window_cleared: assert property (@(posedge clock) disable iff (reset)
      win_done |=> state_ff == ST_ACC && count_ff == '0 && sum_y_ff == '0
                   && sum_xy_ff == '0 && rsp_valid_ff)
      else $error("window not cleared after result");

endmodule

@@ tb/testbench.sv @@
module testbench
   import wrs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam realtime CLK_PERIOD = 4ns;
   localparam int MAX_POINTS = MAX_POINTS_DEFAULT;
   localparam int ITEM_TARGET = 1450;
   localparam int IDLE_PCT = 8;
   localparam int LONG_HOLD = 400;
   localparam int SETTLE_CYCLES = 200;
   localparam int DRAIN_LIMIT = 20000;
   localparam int TIMEOUT_CYCLES = 1_000_000;
   localparam int SAMPLE_MIN = -32768;
   localparam int SAMPLE_MAX = 32767;
   localparam int NPTS_FIELD_MAX = (1 << NPTS_W) - 1;
   localparam int CSR_IDX_LAST = (1 << CSR_IDX_W) - 1;
   localparam longint SLOPE_HI = (longint'(1) << (SLOPE_W - 1)) - 1;
   localparam longint SLOPE_LO = -(longint'(1) << (SLOPE_W - 1));

   localparam int STYLE_RANDOM = 0;
   localparam int STYLE_EXTREME = 1;
   localparam int STYLE_FLAT = 2;
   localparam int STYLE_RAMP = 3;
   localparam int STYLE_LAST = STYLE_RAMP;

   typedef struct {
      logic signed [SLOPE_W-1:0] slope;
      logic signed [MEAN_W-1:0]  mean;
      logic        [SPREAD_W-1:0] spread;
   } fit_type;

   class fit_scoreboard;
      logic [NPTS_W-1:0]          n_reg;
      bit                         bwd;
      int unsigned                count;
      longint                     sum_y;
      longint                     sum_xy;
      logic signed [SAMPLE_W-1:0] lo;
      logic signed [SAMPLE_W-1:0] hi;
      longint unsigned            del;
      fit_type                    expected_fits[$];
      int                         errors;

      function new();
         n_reg = NPTS_RESET;
         bwd = 1'b0;
         errors = 0;
         clear_window();
      endfunction

      function int unsigned window_len();
         int unsigned n;
         n = n_reg;
         if (n < 2) n = 2;
         if (n > MAX_POINTS) n = MAX_POINTS;
         return n;
      endfunction

      function void clear_window();
         longint unsigned n;
         n = window_len();
         count = 0;
         sum_y = 0;
         sum_xy = 0;
         lo = '0;
         hi = '0;
         del = (n * n * (n * n - 1)) / 12;
      endfunction

      // num * 2^16 / den, truncated toward zero
      function longint fixed_quotient(longint num, longint unsigned den);
         longint unsigned mag, q, r, res;
         bit neg;
         neg = num < 0;
         mag = neg ? -num : num;
         if (den == 0) den = 1;
         q = mag / den;
         r = mag % den;
         res = (q << FRAC_BITS) + ((r << FRAC_BITS) / den);
         if (res > (64'd1 << 40)) res = 64'd1 << 40;
         return neg ? -$signed(res) : $signed(res);
      endfunction

      function void write_reg(int idx, logic [CSR_DATA_W-1:0] data);
         if (idx == CSR_N_POINTS) n_reg = data[NPTS_W-1:0];
         else if (idx == CSR_BACKWARD) bwd = data[0];
         else return;
         clear_window();
      endfunction

      function void take_sample(logic signed [SAMPLE_W-1:0] value);
         int unsigned n;
         longint x, y, sx, num, slope_val;
         fit_type fit;
         n = window_len();
         y = value;
         x = bwd ? longint'(n) - longint'(count) : longint'(count) + 1;
         if (count == 0) begin
            lo = value;
            hi = value;
         end else begin
            if (value < lo) lo = value;
            if (value > hi) hi = value;
         end
         sum_y += y;
         sum_xy += x * y;
         count++;
         if (count < n) return;
         sx = longint'(n) * (longint'(n) + 1) / 2;
         num = longint'(n) * sum_xy - sx * sum_y;
         slope_val = fixed_quotient(num, del);
         if (slope_val > SLOPE_HI) slope_val = SLOPE_HI;
         if (slope_val < SLOPE_LO) slope_val = SLOPE_LO;
         fit.slope = SLOPE_W'(slope_val);
         fit.mean = MEAN_W'(fixed_quotient(sum_y, n));
         fit.spread = SPREAD_W'(hi - lo);
         expected_fits.push_back(fit);
         clear_window();
      endfunction

      function void check_fit(logic signed [SLOPE_W-1:0] slope,
                              logic signed [MEAN_W-1:0] mean,
                              logic [SPREAD_W-1:0] spread);
         fit_type fit;
         if (expected_fits.size() == 0) begin
            $display("%0t unexpected result: slope %0d mean %0d spread %0d",
                     $time, slope, mean, spread);
            errors++;
            return;
         end
         fit = expected_fits.pop_front();
         if (slope !== fit.slope) begin
            $display("%0t slope mismatch: expected %0d, got %0d", $time, fit.slope, slope);
            errors++;
         end
         if (mean !== fit.mean) begin
            $display("%0t mean mismatch: expected %0d, got %0d", $time, fit.mean, mean);
            errors++;
         end
         if (spread !== fit.spread) begin
            $display("%0t spread mismatch: expected %0d, got %0d", $time, fit.spread, spread);
            errors++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic signed [SAMPLE_W-1:0]   req_sample;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [SLOPE_W-1:0]    rsp_slope;
   logic signed [MEAN_W-1:0]     rsp_mean;
   logic        [SPREAD_W-1:0]   rsp_spread;
   logic                         csr_valid;
   logic                         csr_ready;
   logic        [CSR_IDX_W-1:0]  csr_index;
   logic        [CSR_DATA_W-1:0] csr_data;

   fit_scoreboard fit_sb;
   int idle_pct = IDLE_PCT;
   int hold_cycles = 0;
   int items_sent = 0;

   window_regression_slope #(.MAX_POINTS(MAX_POINTS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_sample (req_sample),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_slope  (rsp_slope),
      .rsp_mean   (rsp_mean),
      .rsp_spread (rsp_spread),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #(CLK_PERIOD / 2) clock = 1'b1;
      #(CLK_PERIOD / 2) clock = 1'b0;
   end

   // result side: random stall, or a long hold-off when asked for
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_stall <= 1'b1;
            hold_cycles--;
         end else begin
            rsp_stall <= ($urandom_range(99) < idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         fit_sb.check_fit(rsp_slope, rsp_mean, rsp_spread);
   end

   task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_sample <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      fit_sb.take_sample(value);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic stop_sending();
      req_valid <= 1'b0;
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      fit_sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // all results in, then a quiet stretch
   task automatic wait_idle();
      while (fit_sb.expected_fits.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic send_window(input int len, input int style);
      int base, step, v;
      base = $signed(SAMPLE_W'($urandom));
      step = int'($urandom_range(600)) - 300;
      for (int k = 0; k < len; k++) begin
         case (style)
            STYLE_RANDOM: v = $signed(SAMPLE_W'($urandom));
            STYLE_EXTREME: begin
               case ($urandom_range(3))
                  0: v = SAMPLE_MIN;
                  1: v = SAMPLE_MAX;
                  2: v = 0;
                  default: v = -1;
               endcase
            end
            STYLE_FLAT: v = base;
            default: begin
               v = base + step * k + int'($urandom_range(6)) - 3;
               if (v > SAMPLE_MAX) v = SAMPLE_MAX;
               if (v < SAMPLE_MIN) v = SAMPLE_MIN;
            end
         endcase
         send_sample(SAMPLE_W'(v));
      end
   endtask

   initial begin
      #(TIMEOUT_CYCLES * CLK_PERIOD);
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      int phase, r, eff, nwin, per_phase, tail, wait_count;
      logic [CSR_DATA_W-1:0] n_val;

      fit_sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_sample <= '0;
      csr_valid <= 1'b0;
      csr_index <= '0;
      csr_data <= '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset window length: step from full scale to negative full scale
      for (int k = 0; k < NPTS_RESET; k++)
         send_sample(SAMPLE_W'(k < NPTS_RESET / 2 ? SAMPLE_MAX : SAMPLE_MIN));
      stop_sending();
      wait_idle();
      write_csr(CSR_N_POINTS, CSR_DATA_W'(2));
      send_sample(SAMPLE_W'(SAMPLE_MIN));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      stop_sending();
      wait_idle();
      write_csr(CSR_BACKWARD, CSR_DATA_W'(1));
      send_sample(SAMPLE_W'(SAMPLE_MIN));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      stop_sending();
      wait_idle();
      // length below the legal range acts as two
      write_csr(CSR_N_POINTS, CSR_DATA_W'(0));
      send_sample(SAMPLE_W'(1));
      send_sample(SAMPLE_W'(-1));
      stop_sending();
      wait_idle();
      // a write in mid window throws the partial window away
      write_csr(CSR_N_POINTS, CSR_DATA_W'(3));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      stop_sending();
      wait_idle();
      write_csr(CSR_BACKWARD, CSR_DATA_W'(0));
      send_sample(SAMPLE_W'(SAMPLE_MIN));
      stop_sending();
      wait_idle();
      // unknown index leaves the open window alone
      write_csr(CSR_IDX_W'($urandom_range(CSR_BACKWARD + 1, CSR_IDX_LAST)),
                CSR_DATA_W'($urandom));
      send_sample(SAMPLE_W'(0));
      send_sample(SAMPLE_W'(SAMPLE_MAX));
      stop_sending();

      phase = 0;
      while (items_sent < ITEM_TARGET) begin
         wait_idle();
         if (phase == 1) n_val = CSR_DATA_W'(2);
         else if (phase == 4) n_val = CSR_DATA_W'(MAX_POINTS);
         else if (phase == 9)
            n_val = CSR_DATA_W'($urandom_range(MAX_POINTS + 1, NPTS_FIELD_MAX));
         else begin
            r = $urandom_range(99);
            if (r < 55) n_val = CSR_DATA_W'($urandom_range(2, 6));
            else if (r < 75) n_val = CSR_DATA_W'($urandom_range(7, 24));
            else if (r < 85) n_val = CSR_DATA_W'($urandom_range(25, 64));
            else if (r < 93) n_val = CSR_DATA_W'($urandom_range(1));
            else n_val = CSR_DATA_W'($urandom_range(2, 4));
         end
         if ($urandom_range(1)) begin
            write_csr(CSR_N_POINTS, n_val);
            if ($urandom_range(4) != 0) write_csr(CSR_BACKWARD, CSR_DATA_W'($urandom));
         end else begin
            write_csr(CSR_BACKWARD, CSR_DATA_W'($urandom));
            write_csr(CSR_N_POINTS, n_val);
         end
         if ($urandom_range(6) == 0)
            write_csr(CSR_IDX_W'($urandom_range(CSR_BACKWARD + 1, CSR_IDX_LAST)),
                      CSR_DATA_W'($urandom));

         idle_pct = (phase % 7 == 2) ? 0 : IDLE_PCT;
         eff = fit_sb.window_len();
         per_phase = (idle_pct == 0) ? 150 : $urandom_range(30, 90);
         nwin = (per_phase + eff - 1) / eff;
         tail = 0;
         if ($urandom_range(3) == 0)
            tail = $urandom_range(1, eff - 1 < 8 ? eff - 1 : 8);

         // receiver holds off while short windows keep coming
         if (phase == 1) hold_cycles = LONG_HOLD;
         for (int w = 0; w < nwin; w++) begin
            if (phase == 6 && w == nwin / 2) begin
               stop_sending();
               wait_idle();
            end
            send_window(eff, $urandom_range(STYLE_LAST));
         end
         if (tail > 0) send_window(tail, $urandom_range(STYLE_LAST));
         stop_sending();
         phase++;
      end

      idle_pct = IDLE_PCT;
      wait_count = 0;
      while (fit_sb.expected_fits.size() != 0 && wait_count < DRAIN_LIMIT) begin
         @(negedge clock);
         wait_count++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
      if (fit_sb.expected_fits.size() != 0) begin
         $display("%0t %0d results never arrived", $time, fit_sb.expected_fits.size());
         fit_sb.errors++;
      end
      if (fit_sb.errors == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
